FILE: hdl/rsk_pkg.sv
package rsk_pkg;

  // Width of the random word carried by each input transfer.
  localparam int RAND_WIDTH = 31;
  // One remainder bit per cycle in the serial modulo unit.
  localparam int DIV_STEPS  = RAND_WIDTH;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  // Width of the slot index reported with each sample.
  localparam int SLOT_W     = 3;
  // Sample-count register.
  localparam int CFG_W      = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture input transfer, bump seen count
    logic append;    // write element into next free slot
    logic div_step;  // one restoring-modulo step
    logic place;     // overwrite slot j when j < k
    logic read;      // fetch slot at readout index into output register
    logic advance;   // step readout index
    logic clear;     // end of readout: clear counters
  } rsk_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic can_append; // filled count below k
    logic div_done;   // current modulo step is the last one
    logic end_flag;   // held item closes the stream
    logic empty;      // no slot filled
    logic last;       // sample in output register is the final one
  } rsk_sts_t;

endpackage

FILE: hdl/rsk_ctrl.sv
module rsk_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  rsk_pkg::rsk_sts_t sts,
  output rsk_pkg::rsk_cmd_t cmd,
  output logic             in_ready,
  output logic             out_valid
);
  import rsk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHOOSE,
    ST_DIV,
    ST_PLACE,
    ST_CHECK,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SHOW);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHOOSE;
        end
      end
      ST_CHOOSE: begin
        if (sts.can_append) begin
          cmd.append = 1'b1;
          state_next = sts.end_flag ? ST_CHECK : ST_IDLE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.end_flag ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (sts.empty) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          if (sts.last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/rsk_dp.sv
module rsk_dp #(
  parameter int RESERVOIR_DEPTH = 8,
  parameter int VALUE_WIDTH     = 32,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rsk_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [VALUE_WIDTH-1:0]        element_value,
  input  logic [rsk_pkg::RAND_WIDTH-1:0] random_word,
  input  logic                          end_of_stream,
  input  rsk_pkg::rsk_cmd_t             cmd,
  output rsk_pkg::rsk_sts_t             sts,
  output logic [VALUE_WIDTH-1:0]        sample_value,
  output logic [rsk_pkg::SLOT_W-1:0]    slot_index
);
  import rsk_pkg::*;

  localparam int ADDR_W = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
  localparam int FILL_W = $clog2(RESERVOIR_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RESERVOIR_DEPTH);

  logic [CFG_W-1:0]       sample_count;
  logic [VALUE_WIDTH-1:0] elem;
  logic [RAND_WIDTH-1:0]  rnd_sh;
  logic                   end_flag;
  logic [COUNT_WIDTH-1:0] seen;
  logic [COUNT_WIDTH-1:0] rem;
  logic [STEP_W-1:0]      step;
  logic [FILL_W-1:0]      filled;
  logic [ADDR_W-1:0]      idx;
  logic                   last;
  logic [VALUE_WIDTH-1:0] mem [RESERVOIR_DEPTH];

  logic [CMP_W-1:0]       k_ext;
  logic [CMP_W-1:0]       k_eff;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic [COUNT_WIDTH-1:0] rem_next;
  logic                   place_hit;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [FILL_W-1:0]      idx_plus;
  logic [SLOT_W+ADDR_W-1:0] idx_wide;

  // k clipped to the reservoir depth
  assign k_ext = CMP_W'(sample_count);
  assign k_eff = (k_ext > DEPTH_C) ? DEPTH_C : k_ext;

  // restoring modulo step: shift in next random bit, subtract when it fits
  assign trial    = {rem, rnd_sh[RAND_WIDTH-1]};
  assign diff     = trial - {1'b0, seen};
  assign rem_next = (trial >= {1'b0, seen}) ? diff[COUNT_WIDTH-1:0]
                                            : trial[COUNT_WIDTH-1:0];

  assign place_hit = (rem < COUNT_WIDTH'(k_eff));
  assign wr_en     = cmd.append | (cmd.place & place_hit);
  assign wr_addr   = cmd.append ? filled[ADDR_W-1:0] : rem[ADDR_W-1:0];
  assign idx_plus  = FILL_W'(idx) + FILL_W'(1);
  assign idx_wide  = {{SLOT_W{1'b0}}, idx};

  assign sts.can_append = (CMP_W'(filled) < k_eff);
  assign sts.div_done   = (step == STEP_W'(DIV_STEPS - 1));
  assign sts.end_flag   = end_flag;
  assign sts.empty      = (filled == '0);
  assign sts.last       = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= CFG_RESET;
      seen         <= '0;
      filled       <= '0;
      idx          <= '0;
    end else begin
      if (cfg_we) begin
        sample_count <= cfg_wdata;
      end
      if (cmd.load && (seen != '1)) begin
        seen <= seen + COUNT_WIDTH'(1);
      end
      if (cmd.append) begin
        filled <= filled + FILL_W'(1);
      end
      if (cmd.advance) begin
        idx <= idx + ADDR_W'(1);
      end
      if (cmd.clear) begin
        seen   <= '0;
        filled <= '0;
        idx    <= '0;
      end
    end
  end

  // item holding and modulo registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem     <= element_value;
      rnd_sh   <= random_word;
      end_flag <= end_of_stream;
      rem      <= '0;
      step     <= '0;
    end else if (cmd.div_step) begin
      rnd_sh <= {rnd_sh[RAND_WIDTH-2:0], 1'b0};
      rem    <= rem_next;
      step   <= step + STEP_W'(1);
    end
  end

  // reservoir: one write port, registered read into the output register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= elem;
    end
    if (cmd.read) begin
      sample_value <= mem[idx];
      slot_index   <= idx_wide[SLOT_W-1:0];
      last         <= (idx_plus == filled);
    end
  end

endmodule

FILE: hdl/reservoir_sample_k_slots.sv
// Reservoir sampler (Algorithm R) keeping up to k of RESERVOIR_DEPTH slots.
//
// Input channel s_*: one transfer per stream element. s_tdata carries the
// element and a uniform random word; s_tlast marks the stream's last element.
// Output channel m_*: on a stream end the filled slots stream out in slot
// order, one transfer each, m_tlast on the final one; nothing when empty.
// cfg_we/cfg_wdata write k (sample_count); values above the depth act as
// the depth. Write it only while the block is idle.
//
// Timing: an element is taken when s_tready is high (block idle). While the
// reservoir is filling, an element is appended to the next free slot. Once
// full, the slot index j = random mod seen comes from a bit-serial restoring
// modulo unit, one bit per cycle over the 31-bit random word. Readout passes
// a check state, then for each sample a registered reservoir read into the
// output register, which is then presented, plus any stall time.
// A stalled receiver simply holds m_tvalid with stable data; s_tready stays
// low until the readout finishes, then counters clear and the block idles.
// Reset (rst, synchronous) clears the counters and sets k to 8; reservoir
// contents are not cleared and are only read after being written.
module reservoir_sample_k_slots #(
  parameter int  RESERVOIR_DEPTH = 8,
  parameter int  VALUE_WIDTH     = 32,
  parameter int  COUNT_WIDTH     = 32,
  localparam int S_W = ((VALUE_WIDTH + rsk_pkg::RAND_WIDTH + 7) / 8) * 8,
  localparam int M_W = ((VALUE_WIDTH + rsk_pkg::SLOT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rsk_pkg::CFG_W-1:0] cfg_wdata,  // sample_count
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [S_W-1:0]            s_tdata,    // element_value, random_word, zero pad
  input  logic                      s_tlast,    // end_of_stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [M_W-1:0]            m_tdata,    // sample_value, slot_index, zero pad
  output logic                      m_tlast     // last_sample
);
  import rsk_pkg::*;

  rsk_cmd_t               cmd;
  rsk_sts_t               sts;
  logic [VALUE_WIDTH-1:0] element_value;
  logic [RAND_WIDTH-1:0]  random_word;
  logic [VALUE_WIDTH-1:0] sample_value;
  logic [SLOT_W-1:0]      slot_index;

  assign element_value = s_tdata[VALUE_WIDTH-1:0];
  assign random_word   = s_tdata[VALUE_WIDTH +: RAND_WIDTH];

  rsk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  rsk_dp #(
    .RESERVOIR_DEPTH (RESERVOIR_DEPTH),
    .VALUE_WIDTH     (VALUE_WIDTH),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .element_value (element_value),
    .random_word   (random_word),
    .end_of_stream (s_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .sample_value  (sample_value),
    .slot_index    (slot_index)
  );

  // output register lives in the datapath; pad up to whole bytes
  assign m_tdata = M_W'({slot_index, sample_value});
  assign m_tlast = sts.last;

`ifndef NO_ASSERTIONS
  // input side and output side are never open in the same cycle
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input ready while a sample is presented");

  // accepting an element always makes the block busy and drops s_tready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready again right after accepting an element");

  // final sample transfer returns the block to idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not idle after final sample");
`endif

endmodule

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsk_pkg::*;

  localparam int DEPTH        = 8;
  localparam int VALUE_W      = 32;
  localparam int S_W          = 64;   // element (32) + random word (31) + pad
  localparam int M_W          = 40;   // sample (32) + slot (3) + pad
  localparam int RANDOM_ITEMS = 250;
  // Room for one element in the replacement phase to finish; leave margin.
  localparam int DRAIN_CYCLES = 48;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [VALUE_W-1:0]    elem;
    logic [RAND_WIDTH-1:0] rnd;
    logic                  eos;
  } stream_item_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } sample_t;

  // DUT-facing signals; every DUT input is driven to a known value from time zero.
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = CFG_RESET;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [S_W-1:0]   s_tdata   = '0;   // element_value, random_word, zero pad
  logic             s_tlast   = 1'b0; // end_of_stream
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [M_W-1:0]   m_tdata;          // sample_value, slot_index, zero pad
  logic             m_tlast;          // last_sample

  // Stimulus and scoreboard state.
  stream_item_t pending_items[$];
  sample_t      expected_samples[$];
  int           send_idle_pct  = 23;
  int           recv_idle_pct  = 70;
  logic         in_fire        = 1'b0;
  int           quiet_cycles   = 0;
  int           errors         = 0;
  int           elements_in    = 0;
  int           streams_closed = 0;
  int           samples_checked = 0;
  int           k_writes       = 0;

  // Shadow copy of the sampler state.
  logic [VALUE_W-1:0] slots_model[DEPTH];
  logic [31:0]        seen_model = '0;
  int unsigned        fill_model = 0;
  logic [CFG_W-1:0]   k_model    = CFG_RESET;

  always #5ns clk = ~clk;

  reservoir_sample_k_slots dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  task automatic report_error(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Algorithm R step on the shadow state; an end element queues the readout.
  function automatic void reservoir_update(stream_item_t it);
    logic [31:0] j;
    int unsigned eff_k;
    sample_t     smp;
    eff_k = (k_model > DEPTH) ? DEPTH : k_model;
    if (seen_model != '1) seen_model++;
    if (fill_model < eff_k) begin
      slots_model[fill_model] = it.elem;
      fill_model++;
    end else begin
      // seen is at least 1 here
      j = {1'b0, it.rnd} % seen_model;
      if (j < eff_k) slots_model[j[2:0]] = it.elem;
    end
    if (it.eos) begin
      for (int i = 0; i < fill_model; i++) begin
        smp.value = slots_model[i];
        smp.slot  = SLOT_W'(i);
        smp.last  = (i == fill_model - 1);
        expected_samples.insert(expected_samples.size(), smp);
      end
      streams_closed++;
      seen_model = '0;
      fill_model = 0;
    end
  endfunction

  // Driver: inputs move on the falling edge. A held item stays put until
  // the rising edge reports its transfer; the receiver stalls at random.
  always @(negedge clk) begin
    stream_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        s_tdata  <= {1'b0, nxt.rnd, nxt.elem};
        s_tlast  <= nxt.eos;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: everything is sampled on the rising edge. Register writes and
  // input transfers update the shadow state, output transfers are checked
  // against the oldest expected sample.
  always @(posedge clk) begin
    sample_t want;
    in_fire <= s_tvalid && s_tready;
    if (rst) begin
      k_model      = CFG_RESET;
      seen_model   = '0;
      fill_model   = 0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_we) k_model = cfg_wdata;
      if (s_tvalid && s_tready) begin
        elements_in++;
        reservoir_update('{elem: s_tdata[VALUE_W-1:0],
                           rnd:  s_tdata[VALUE_W +: RAND_WIDTH],
                           eos:  s_tlast});
      end
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_error($sformatf("unexpected sample %h slot %0d last %0b",
                                 m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: SLOT_W], m_tlast));
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata[VALUE_W-1:0] !== want.value ||
              m_tdata[VALUE_W +: SLOT_W] !== want.slot || m_tlast !== want.last)
            report_error($sformatf(
              "sample mismatch: expected %h slot %0d last %0b, got %h slot %0d last %0b",
              want.value, want.slot, want.last,
              m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: SLOT_W], m_tlast));
          samples_checked++;
        end
      end
      quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ? 0
                                                                          : quiet_cycles + 1;
    end
  end

  // Hang detection: too long without a single transfer on either side.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic queue_item(logic [VALUE_W-1:0] elem, logic [RAND_WIDTH-1:0] rnd, logic eos);
    stream_item_t it;
    it = '{elem: elem, rnd: rnd, eos: eos};
    pending_items.insert(pending_items.size(), it);
  endtask

  // Block idle: nothing left to send or to receive, then room for a
  // replacement-phase element that produces no transfer to finish.
  task automatic wait_idle();
    while (pending_items.size() != 0 || s_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_sample_count(logic [CFG_W-1:0] k);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we    <= 1'b0;
    k_writes++;
  endtask

  initial begin
    int rand_items;
    int len;
    logic closes;
    logic [RAND_WIDTH-1:0] rw;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed ---
    // Reset k of 8: fill all slots with edge patterns, then two
    // replacements: random word 0 hits slot 0, the largest word mod 10
    // lands on slot 7 and closes the stream.
    @(posedge clk);
    queue_item(32'h0000_0000, '0, 1'b0);
    queue_item(32'hFFFF_FFFF, '1, 1'b0);
    queue_item(32'hA5A5_A5A5, 31'h2AAA_AAAA, 1'b0);
    queue_item(32'h5A5A_5A5A, 31'h5555_5555, 1'b0);
    queue_item(32'h0000_0001, 31'd1, 1'b0);
    queue_item(32'h0000_0002, 31'd2, 1'b0);
    queue_item(32'h0000_0003, 31'd3, 1'b0);
    queue_item(32'h0000_0004, 31'd4, 1'b0);
    queue_item(32'h8000_0000, '0, 1'b0);
    queue_item(32'h7FFF_FFFF, '1, 1'b1);

    // k of zero: nothing stored, so the end element reads out nothing
    set_sample_count(4'd0);
    @(posedge clk);
    queue_item(32'hDEAD_BEEF, 31'd0, 1'b1);

    // single-sample case
    set_sample_count(4'd1);
    @(posedge clk);
    queue_item(32'h1234_5678, 31'd5, 1'b0);
    queue_item(32'h9ABC_DEF0, 31'd3, 1'b0);
    queue_item(32'h0F0F_0F0F, 31'd6, 1'b1);

    // k above depth acts as the depth
    set_sample_count(4'd15);
    @(posedge clk);
    for (int n = 0; n < 9; n++)
      queue_item($urandom, 31'($urandom), n == 8);

    // --- random ---
    // Streams of random length with random k. Some are left open so the
    // next k write lands mid-stream. Idle mix changes by thirds.
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 60)
        set_sample_count(($urandom_range(3) == 0) ? CFG_W'($urandom_range(15))
                                                  : CFG_W'($urandom_range(8, 1)));
      @(posedge clk);
      if (rand_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_items >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 23;
      end
      len    = $urandom_range(20, 1);
      closes = ($urandom_range(99) < 85);
      for (int n = 0; n < len; n++) begin
        rw = $urandom_range(1) ? RAND_WIDTH'($urandom) : RAND_WIDTH'($urandom_range(63));
        queue_item($urandom, rw, closes && (n == len - 1));
      end
      rand_items += len;
      while (pending_items.size() > 4) @(posedge clk);
    end

    // close whatever stream is still open so every slot gets read back
    @(posedge clk);
    queue_item($urandom, RAND_WIDTH'($urandom), 1'b1);

    wait_idle();
    if (expected_samples.size() != 0)
      report_error($sformatf("%0d expected samples never arrived", expected_samples.size()));

    $display("Ran %0d elements in %0d closed streams, %0d samples compared.",
             elements_in, streams_closed, samples_checked);
    $display("k rewritten %0d times (0, 1, 15 and random after reset 8); %0d mismatches.",
             k_writes, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
